/* rtl/tpfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_pkg
// Shared types and constants for the triac phase-angle firing controller.
// ----------------------------------------------------------------------------
package tpfc_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LINES_W = 3;
  localparam int unsigned ACC_W   = 16;

  // Fire delay after reset.
  localparam logic [BYTE_W-1:0] FIRE_DELAY_RESET = 8'h2E;

  // Default number of current samples in one sum.
  localparam int unsigned SAMPLES_PER_SUM_DEFAULT = 20;

  // Input event codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 2'd0,
    KIND_ZERO_CROSS = 2'd1,
    KIND_RX_BYTE    = 2'd2,
    KIND_SAMPLE     = 2'd3
  } kind_t;

  // Outcome of one input event, handed from the core to the result stage.
  typedef struct packed {
    logic               gate;
    logic [LINES_W-1:0] out_bits;
    logic               reply;
    logic [BYTE_W-1:0]  reply_hi;
    logic [BYTE_W-1:0]  reply_lo;
    logic [BYTE_W-1:0]  reply_tail;
  } step_result_t;

endpackage

/* rtl/tpfc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_in_if
// Input event channel: valid/ready handshake with event kind and value.
// ----------------------------------------------------------------------------
interface tpfc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tpfc_pkg::KIND_W-1:0]  kind;
  logic [tpfc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

/* rtl/tpfc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_out_if
// Result channel: valid/ready handshake with gate, lines and reply byte.
// ----------------------------------------------------------------------------
interface tpfc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         gate;
  logic [tpfc_pkg::LINES_W-1:0] out_bits;
  logic                         tx_valid;
  logic [tpfc_pkg::BYTE_W-1:0]  tx_byte;
  logic                         last;

  modport source (
    output valid, output gate, output out_bits, output tx_valid, output tx_byte,
    output last, input ready
  );
  modport sink (
    input valid, input gate, input out_bits, input tx_valid, input tx_byte,
    input last, output ready
  );
endinterface

/* rtl/tpfc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpfc_core
// Controller state: phase counter, gate, command frame and current sum.
// Updates on every accepted event and reports the state after the event.
// ----------------------------------------------------------------------------
module tpfc_core #(
  parameter int unsigned SAMPLES_PER_SUM = tpfc_pkg::SAMPLES_PER_SUM_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [tpfc_pkg::KIND_W-1:0]  kind,
  input  logic [tpfc_pkg::VALUE_W-1:0] value,
  output tpfc_pkg::step_result_t       result
);

  localparam int unsigned IDX_W  = (SAMPLES_PER_SUM > 1) ? $clog2(SAMPLES_PER_SUM) : 1;
  localparam int unsigned BW     = tpfc_pkg::BYTE_W;
  localparam int unsigned LW     = tpfc_pkg::LINES_W;
  localparam int unsigned AW     = tpfc_pkg::ACC_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_SUM - 1);

  logic [BW-1:0]    phase_count, phase_count_next;
  logic [BW-1:0]    fire_delay, fire_delay_next;
  logic             gate_on, gate_on_next;
  logic [LW-1:0]    switch_lines, switch_lines_next;
  logic [BW-1:0]    frame_first, frame_first_next;
  logic [BW-1:0]    frame_second, frame_second_next;
  logic             frame_position, frame_position_next;
  logic [AW-1:0]    sample_accumulator, sample_accumulator_next;
  logic [IDX_W-1:0] sample_index, sample_index_next;
  logic [AW-1:0]    latched_current, latched_current_next;
  logic [AW-1:0]    acc_sum;
  logic [BW-1:0]    rx_byte;
  logic             reply;

  assign rx_byte = value[BW-1:0];
  // Each sample is added twice, so the sum takes the sample shifted left once.
  assign acc_sum = sample_accumulator + {{(AW-tpfc_pkg::VALUE_W-1){1'b0}}, value, 1'b0};

  // Next state for one event.
  always_comb begin
    phase_count_next        = phase_count;
    fire_delay_next         = fire_delay;
    gate_on_next            = gate_on;
    switch_lines_next       = switch_lines;
    frame_first_next        = frame_first;
    frame_second_next       = frame_second;
    frame_position_next     = frame_position;
    sample_accumulator_next = sample_accumulator;
    sample_index_next       = sample_index;
    latched_current_next    = latched_current;
    reply                   = 1'b0;
    unique case (tpfc_pkg::kind_t'(kind))
      tpfc_pkg::KIND_TICK: begin
        phase_count_next = phase_count + 1'b1;
        if (phase_count_next == fire_delay && switch_lines[2:1] != 2'b00) begin
          gate_on_next = 1'b1;
        end
      end
      tpfc_pkg::KIND_ZERO_CROSS: begin
        phase_count_next = '0;
        gate_on_next     = 1'b0;
        fire_delay_next  = frame_first;
      end
      tpfc_pkg::KIND_RX_BYTE: begin
        if (!frame_position) begin
          frame_first_next    = rx_byte;
          frame_position_next = 1'b1;
        end else begin
          frame_second_next   = rx_byte;
          frame_position_next = 1'b0;
          switch_lines_next   = rx_byte[LW-1:0];
          reply               = 1'b1;
        end
      end
      tpfc_pkg::KIND_SAMPLE: begin
        if (sample_index == IDX_LAST) begin
          latched_current_next    = acc_sum;
          sample_accumulator_next = '0;
          sample_index_next       = '0;
        end else begin
          sample_accumulator_next = acc_sum;
          sample_index_next       = sample_index + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count        <= '0;
      fire_delay         <= tpfc_pkg::FIRE_DELAY_RESET;
      gate_on            <= 1'b0;
      switch_lines       <= '0;
      frame_first        <= '0;
      frame_second       <= '0;
      frame_position     <= 1'b0;
      sample_accumulator <= '0;
      sample_index       <= '0;
      latched_current    <= '0;
    end else if (accept) begin
      phase_count        <= phase_count_next;
      fire_delay         <= fire_delay_next;
      gate_on            <= gate_on_next;
      switch_lines       <= switch_lines_next;
      frame_first        <= frame_first_next;
      frame_second       <= frame_second_next;
      frame_position     <= frame_position_next;
      sample_accumulator <= sample_accumulator_next;
      sample_index       <= sample_index_next;
      latched_current    <= latched_current_next;
    end
  end

  // Outcome of the event as seen after the update.
  always_comb begin
    result.gate       = gate_on_next;
    result.out_bits   = switch_lines_next;
    result.reply      = reply;
    result.reply_hi   = latched_current[AW-1:BW];
    result.reply_lo   = latched_current[BW-1:0];
    result.reply_tail = frame_second_next;
  end

endmodule

/* rtl/triac_phase_fire_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triac_phase_fire_controller_top
// Phase-angle triac firing controller with a two-byte serial command frame.
// ----------------------------------------------------------------------------
// Each event beat (tick, zero crossing, received byte or current sample)
// updates the controller state in the cycle it is accepted, and its results
// are held in a result register. Most events give one result beat, so the
// block takes one event per clock as long as the result side keeps up. A
// received byte that completes a frame gives three result beats (current sum
// high byte, low byte, second frame byte); the single result register sends
// them one per clock while the result side keeps up, and takes no new event
// until the last pending beat leaves; the next is taken in that same cycle.
// ----------------------------------------------------------------------------
module triac_phase_fire_controller_top #(
  parameter int unsigned SAMPLES_PER_SUM = tpfc_pkg::SAMPLES_PER_SUM_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  tpfc_in_if.sink   item,
  tpfc_out_if.source result
);

  localparam int unsigned BW = tpfc_pkg::BYTE_W;

  tpfc_pkg::step_result_t step;
  logic                   accept;
  logic [1:0]             beats_left;
  logic                   gate;
  logic [tpfc_pkg::LINES_W-1:0] out_bits;
  logic                   reply;
  logic [BW-1:0]          reply_hi;
  logic [BW-1:0]          reply_lo;
  logic [BW-1:0]          reply_tail;
  logic                   drain_last;

  // A new event enters when the result register is empty or frees this cycle.
  assign drain_last   = (beats_left == 2'd1) && result.ready;
  assign item.ready   = (beats_left == 2'd0) || drain_last;
  assign accept       = item.valid && item.ready;

  tpfc_core #(
    .SAMPLES_PER_SUM(SAMPLES_PER_SUM)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (item.kind),
    .value  (item.value),
    .result (step)
  );

  // Beat counter of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      beats_left <= 2'd0;
    end else if (accept) begin
      beats_left <= step.reply ? 2'd3 : 2'd1;
    end else if (result.valid && result.ready) begin
      beats_left <= beats_left - 2'd1;
    end
  end

  // Result payload, loaded with each accepted event.
  always_ff @(posedge clk) begin
    if (accept) begin
      gate       <= step.gate;
      out_bits   <= step.out_bits;
      reply      <= step.reply;
      reply_hi   <= step.reply_hi;
      reply_lo   <= step.reply_lo;
      reply_tail <= step.reply_tail;
    end
  end

  // Pick the reply byte for the beat on the port.
  always_comb begin
    result.valid    = (beats_left != 2'd0);
    result.gate     = gate;
    result.out_bits = out_bits;
    result.tx_valid = reply;
    result.last     = (beats_left == 2'd1);
    result.tx_byte  = '0;
    if (reply) begin
      unique case (beats_left)
        2'd3:    result.tx_byte = reply_hi;
        2'd2:    result.tx_byte = reply_lo;
        default: result.tx_byte = reply_tail;
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triac phase-angle firing controller.
// ----------------------------------------------------------------------------
// Event beats (ticks, zero crossings, received bytes and current samples) are
// queued by the stimulus process and driven by a clocked driver. Every
// accepted event is run through a local copy of the controller state, which
// produces the result beats the block must send. A clocked monitor checks each
// result beat, field by field, against the oldest beat still due. The stimulus
// runs a directed section, then random sequences with random gaps and stalls
// on both sides. It also includes a long result-side hold and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned N_SAMPLES   = tpfc_pkg::SAMPLES_PER_SUM_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 160;
  localparam int unsigned MAX_IDLE    = 13;

  typedef struct {
    tpfc_pkg::kind_t              kind;
    logic [tpfc_pkg::VALUE_W-1:0] value;
    int unsigned                  gap;
    bit                           drain;
  } ctl_event_t;

  typedef struct packed {
    logic                         gate;
    logic [tpfc_pkg::LINES_W-1:0] out_bits;
    logic                         tx_valid;
    logic [tpfc_pkg::BYTE_W-1:0]  tx_byte;
    logic                         last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpfc_in_if  ev_if ();
  tpfc_out_if res_if ();

  triac_phase_fire_controller_top #(
    .SAMPLES_PER_SUM(N_SAMPLES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (ev_if),
    .result (res_if)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus queue and the beats that the controller still owes.
  ctl_event_t  event_queue[$];
  beat_t       due_beats[$];
  int unsigned n_errors   = 0;
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_cycles   = 0;

  // Idling controls set per phase by the stimulus process.
  bit src_idle  = 1'b0;
  bit sink_idle = 1'b0;
  int unsigned hold_req = 0;

  logic ev_fire  = 1'b0;
  logic res_fire = 1'b0;

  // Local copy of the controller state.
  logic [tpfc_pkg::BYTE_W-1:0]  phase_cnt   = '0;
  logic [tpfc_pkg::BYTE_W-1:0]  fire_delay  = tpfc_pkg::FIRE_DELAY_RESET;
  logic                         gate_on     = 1'b0;
  logic [tpfc_pkg::LINES_W-1:0] lines       = '0;
  logic [tpfc_pkg::BYTE_W-1:0]  frame_first = '0;
  logic [tpfc_pkg::BYTE_W-1:0]  frame_tail  = '0;
  logic                         frame_pos   = 1'b0;
  logic [tpfc_pkg::ACC_W-1:0]   sample_acc  = '0;
  int unsigned                  sample_idx  = 0;
  logic [tpfc_pkg::ACC_W-1:0]   current_sum = '0;

  // Apply one accepted event to the local state and record the beats it owes.
  task automatic step_controller(input tpfc_pkg::kind_t kind,
                                 input logic [tpfc_pkg::VALUE_W-1:0] value);
    bit frame_done;
    frame_done = 1'b0;
    case (kind)
      tpfc_pkg::KIND_TICK: begin
        phase_cnt = phase_cnt + 8'd1;
        if (phase_cnt == fire_delay && lines[2:1] != 2'b00) gate_on = 1'b1;
      end
      tpfc_pkg::KIND_ZERO_CROSS: begin
        phase_cnt  = '0;
        gate_on    = 1'b0;
        fire_delay = frame_first;
      end
      tpfc_pkg::KIND_RX_BYTE: begin
        if (!frame_pos) begin
          frame_first = value[tpfc_pkg::BYTE_W-1:0];
          frame_pos   = 1'b1;
        end else begin
          frame_tail = value[tpfc_pkg::BYTE_W-1:0];
          frame_pos  = 1'b0;
          lines      = frame_tail[tpfc_pkg::LINES_W-1:0];
          frame_done = 1'b1;
        end
      end
      default: begin
        // Each sample is added twice; the sum wraps at 16 bits.
        sample_acc = sample_acc + {5'd0, value, 1'b0};
        if (sample_idx + 1 >= N_SAMPLES) begin
          current_sum = sample_acc;
          sample_acc  = '0;
          sample_idx  = 0;
        end else begin
          sample_idx = sample_idx + 1;
        end
      end
    endcase
    if (frame_done) begin
      due_beats.push_back('{gate_on, lines, 1'b1, current_sum[15:8], 1'b0});
      due_beats.push_back('{gate_on, lines, 1'b1, current_sum[7:0], 1'b0});
      due_beats.push_back('{gate_on, lines, 1'b1, frame_tail, 1'b1});
    end else begin
      due_beats.push_back('{gate_on, lines, 1'b0, 8'd0, 1'b1});
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Monitor: check result beats, then feed accepted events to the local state.
  always @(posedge clk) begin
    beat_t want;
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (due_beats.size() == 0) begin
          $error("result beat with nothing due");
          n_errors++;
        end else begin
          want = due_beats.pop_front();
          check_field("gate", 8'(want.gate), 8'(res_if.gate));
          check_field("out_bits", 8'(want.out_bits), 8'(res_if.out_bits));
          check_field("tx_valid", 8'(want.tx_valid), 8'(res_if.tx_valid));
          check_field("tx_byte", want.tx_byte, res_if.tx_byte);
          check_field("last", 8'(want.last), 8'(res_if.last));
        end
      end
      if (ev_if.valid && ev_if.ready) begin
        step_controller(tpfc_pkg::kind_t'(ev_if.kind), ev_if.value);
        n_accepted++;
      end
    end
    ev_fire  <= !rst && ev_if.valid && ev_if.ready;
    res_fire <= !rst && res_if.valid && res_if.ready;
  end

  // Event driver: holds each beat until accepted, then waits out the next gap.
  ctl_event_t  cur_event;
  bit          have_event = 1'b0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      ev_if.valid <= 1'b0;
    end else if (!ev_if.valid || ev_fire) begin
      // A drain beat waits until every owed result beat has left.
      if (!have_event && event_queue.size() > 0 &&
          !(event_queue[0].drain && due_beats.size() > 0)) begin
        cur_event  = event_queue.pop_front();
        have_event = 1'b1;
        gap_left   = cur_event.gap;
      end
      if (have_event && gap_left == 0) begin
        ev_if.valid <= 1'b1;
        ev_if.kind  <= cur_event.kind;
        ev_if.value <= cur_event.value;
        have_event  = 1'b0;
      end else begin
        if (have_event) gap_left--;
        ev_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls per beat, plus an occasional long hold.
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (res_fire) stall_left = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic void queue_event(input tpfc_pkg::kind_t kind,
                                      input logic [tpfc_pkg::VALUE_W-1:0] value,
                                      input bit drain = 1'b0);
    ctl_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.gap   = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
    ev.drain = drain;
    event_queue.push_back(ev);
    n_queued++;
  endfunction

  // Field values biased toward the extremes.
  function automatic logic [tpfc_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return tpfc_pkg::VALUE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Random traffic built mostly from well-formed sequences.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned added;
    int unsigned pick;
    int unsigned len;
    logic [tpfc_pkg::VALUE_W-1:0] delay_val;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Command frame; mostly short delays so the gate fires within a burst.
        delay_val = ($urandom_range(0, 3) == 0) ? pick_value()
                                                : tpfc_pkg::VALUE_W'($urandom_range(0, 40));
        queue_event(tpfc_pkg::KIND_RX_BYTE, delay_val, $urandom_range(0, 19) == 0);
        queue_event(tpfc_pkg::KIND_RX_BYTE, pick_value());
        added += 2;
      end else if (pick < 45) begin
        queue_event(tpfc_pkg::KIND_ZERO_CROSS, pick_value());
        added++;
      end else if (pick < 70) begin
        len = $urandom_range(1, 45);
        repeat (len) queue_event(tpfc_pkg::KIND_TICK, pick_value());
        added += len;
      end else if (pick < 88) begin
        len = ($urandom_range(0, 2) == 0) ? N_SAMPLES : $urandom_range(1, 8);
        repeat (len) queue_event(tpfc_pkg::KIND_SAMPLE, pick_value());
        added += len;
      end else begin
        queue_event(tpfc_pkg::kind_t'($urandom_range(0, 3)), pick_value());
        added++;
      end
    end
  endtask

  // Wait until every queued event is accepted and every owed beat has left.
  task automatic wait_drained();
    while (n_accepted != n_queued || due_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    ev_if.valid  = 1'b0;
    ev_if.kind   = tpfc_pkg::KIND_TICK;
    ev_if.value  = '0;
    res_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed section with idling on both sides.
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    queue_event(tpfc_pkg::KIND_TICK, 10'h3FF);         // no lines on, gate stays off
    queue_event(tpfc_pkg::KIND_ZERO_CROSS, 10'h155);   // delay from an empty frame
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h302);      // byte above 255 keeps low bits
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h3FE);      // lines 1 and 2, reply sum of zeros
    queue_event(tpfc_pkg::KIND_ZERO_CROSS, 10'h000);
    queue_event(tpfc_pkg::KIND_TICK, 10'h000);
    queue_event(tpfc_pkg::KIND_TICK, 10'h2AA);         // counter reaches delay, gate on
    queue_event(tpfc_pkg::KIND_TICK, 10'h155);         // gate already on stays on
    queue_event(tpfc_pkg::KIND_ZERO_CROSS, 10'h3FF);   // gate off
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h0FF);
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h001);      // only line 0: no firing
    queue_event(tpfc_pkg::KIND_ZERO_CROSS, 10'h000);
    queue_event(tpfc_pkg::KIND_TICK, 10'h000);
    queue_event(tpfc_pkg::KIND_TICK, 10'h000);
    queue_event(tpfc_pkg::KIND_SAMPLE, 10'h3FF);
    queue_event(tpfc_pkg::KIND_SAMPLE, 10'h000);
    queue_event(tpfc_pkg::KIND_SAMPLE, 10'h2AA);
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h100);
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h004);      // line 2 alone enables firing
    queue_event(tpfc_pkg::KIND_ZERO_CROSS, 10'h000);
    queue_event(tpfc_pkg::KIND_TICK, 10'h3FF);
    queue_event(tpfc_pkg::KIND_RX_BYTE, 10'h3C1);      // a lone byte shifts the frame
    wait_drained();

    // Random traffic, both sides idling.
    random_traffic(50);
    wait_drained();

    // Back-to-back traffic with no idling.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    random_traffic(35);
    wait_drained();

    // Result side holds off while events keep coming, so the block backs up.
    hold_req++;
    random_traffic(30);
    wait_drained();

    // Sender gaps only, then both sides idling again.
    src_idle = 1'b1;
    random_traffic(30);
    sink_idle = 1'b1;
    random_traffic(30);
    wait_drained();

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
